// ----- hw/rtl/met_pkg.sv -----
// Shared constants and types for the escape-time iteration core.
`default_nettype none

package met_pkg;

    localparam int FRAC_BITS    = 28;
    localparam int COUNT_BITS   = 16;
    localparam int IN_FRAC      = 28;
    localparam int INT_BITS     = 20;
    localparam int CFG_W        = 16;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    localparam logic [CFG_W-1:0] DEF_MAX_ITER = 16'd512;
    localparam logic [CFG_W-1:0] DEF_ESCAPE   = 16'd40000;

    localparam logic CFG_IDX_MAX_ITER = 1'b0;
    localparam logic CFG_IDX_ESCAPE   = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] max_iter;
        logic [CFG_W-1:0] esc_lim;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hw/rtl/met_mul.sv -----
// Shared multi-cycle signed multiplier built from four registered limb products.
`default_nettype none

module met_mul #(
    parameter int OP_W = met_pkg::FRAC_BITS + met_pkg::INT_BITS + 1
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic signed [OP_W-1:0]         i_a,
    input  wire logic signed [OP_W-1:0]         i_b,
    output logic                                o_done,
    output logic signed [4*((OP_W+1)/2)-1:0]    o_prod
);

    localparam int LB = (OP_W + 1) / 2;
    localparam int HW = 2 * LB;
    localparam int PW = 4 * LB;

    logic              r_busy;
    logic [2:0]        r_cnt;
    logic              r_done;
    logic [HW-1:0]     r_mag_a;
    logic [HW-1:0]     r_mag_b;
    logic              r_neg;
    logic [HW-1:0]     r_pp;
    logic [1:0]        r_pp_k;
    logic [PW-1:0]     r_acc;
    logic signed [PW-1:0] r_prod;

    logic [OP_W-1:0]   w_abs_a;
    logic [OP_W-1:0]   w_abs_b;
    logic [LB-1:0]     w_limb_a;
    logic [LB-1:0]     w_limb_b;
    logic [PW-1:0]     w_pp_sh;

    assign w_abs_a  = i_a[OP_W-1] ? OP_W'(-i_a) : OP_W'(i_a);
    assign w_abs_b  = i_b[OP_W-1] ? OP_W'(-i_b) : OP_W'(i_b);
    assign w_limb_a = r_cnt[0] ? r_mag_a[HW-1:LB] : r_mag_a[LB-1:0];
    assign w_limb_b = r_cnt[1] ? r_mag_b[HW-1:LB] : r_mag_b[LB-1:0];

    always_comb begin
        case (r_pp_k)
            2'd0:    w_pp_sh = PW'(r_pp);
            2'd3:    w_pp_sh = PW'(r_pp) << HW;
            default: w_pp_sh = PW'(r_pp) << LB;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag_a <= HW'(w_abs_a);
            r_mag_b <= HW'(w_abs_b);
            r_neg   <= i_a[OP_W-1] ^ i_b[OP_W-1];
            r_acc   <= '0;
        end else if (r_busy) begin
            if (r_cnt < 3'd4) begin
                r_pp   <= HW'(w_limb_a) * HW'(w_limb_b);
                r_pp_k <= r_cnt[1:0];
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_acc <= r_acc + w_pp_sh;
            end
            if (r_cnt == 3'd5) begin
                r_prod <= r_neg ? $signed(-r_acc) : $signed(r_acc);
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- hw/rtl/met_cfg.sv -----
// APB register file holding the iteration limit and the escape bound.
`default_nettype none

module met_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [met_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [met_pkg::DATA_W-1:0]    pwdata,
    output logic [met_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    output met_pkg::t_cfg                      o_cfg
);

    met_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_iter <= met_pkg::DEF_MAX_ITER;
            r_cfg.esc_lim  <= met_pkg::DEF_ESCAPE;
        end else if (w_wr) begin
            unique case (paddr[2])
                met_pkg::CFG_IDX_MAX_ITER: r_cfg.max_iter <= pwdata[met_pkg::CFG_W-1:0];
                met_pkg::CFG_IDX_ESCAPE:   r_cfg.esc_lim  <= pwdata[met_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            met_pkg::CFG_IDX_MAX_ITER: prdata = met_pkg::DATA_W'(r_cfg.max_iter);
            met_pkg::CFG_IDX_ESCAPE:   prdata = met_pkg::DATA_W'(r_cfg.esc_lim);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hw/rtl/mandelbrot_escape_time_core.sv -----
// Top level: per-pass sequencer around one shared multiplier for escape-time iteration.
// Each pass runs four multiplies on the shared unit, MA, MB, SR and SI in that order, then a test.
// One point is worked on at a time, and the input is ready again in the same cycle that
// the result is registered; a result still waiting on the output holds the final test
// of the next point.
// Synchronous active-low reset restores max_iterations to 512 and escape_limit_sq to 40000.
`default_nettype none

module mandelbrot_escape_time_core #(
    parameter int FRAC_BITS  = met_pkg::FRAC_BITS,
    parameter int COUNT_BITS = met_pkg::COUNT_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [31:0]            i_c_re,
    input  wire logic signed [31:0]            i_c_im,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [15:0]                        o_step_count,
    output logic                               o_in_set,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [met_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [met_pkg::DATA_W-1:0]    pwdata,
    output logic [met_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam int ZW = FRAC_BITS + met_pkg::INT_BITS;
    localparam int MW = ZW + 1;
    localparam int LB = (MW + 1) / 2;
    localparam int PW = 4 * LB;
    localparam int SW = 2 * ZW;
    localparam int LW = (COUNT_BITS > met_pkg::CFG_W) ? COUNT_BITS : met_pkg::CFG_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MA   = 3'd1;
    localparam logic [2:0] S_MB   = 3'd2;
    localparam logic [2:0] S_SR   = 3'd3;
    localparam logic [2:0] S_SI   = 3'd4;
    localparam logic [2:0] S_TEST = 3'd5;

    met_pkg::t_cfg w_cfg;

    logic [2:0]              r_state;
    logic                    r_wait;
    logic signed [ZW-1:0]    r_cr;
    logic signed [ZW-1:0]    r_ci;
    logic signed [ZW-1:0]    r_zr;
    logic signed [ZW-1:0]    r_zi;
    logic signed [ZW-1:0]    r_nr;
    logic signed [ZW-1:0]    r_ni;
    logic [SW-1:0]           r_sr;
    logic [SW-1:0]           r_sum;
    logic [COUNT_BITS-1:0]   r_count;
    logic                    r_out_valid;
    logic [COUNT_BITS-1:0]   r_res_count;
    logic                    r_res_in_set;

    logic signed [ZW-1:0]    w_cr_in;
    logic signed [ZW-1:0]    w_ci_in;
    logic signed [ZW-1:0]    w_cre_ext;
    logic signed [ZW-1:0]    w_cim_ext;
    logic signed [MW-1:0]    w_op_a;
    logic signed [MW-1:0]    w_op_b;
    logic                    w_start;
    logic                    w_done;
    logic signed [PW-1:0]    w_prod;
    logic signed [ZW-1:0]    w_nr_new;
    logic signed [ZW-1:0]    w_ni_new;
    logic [LW-1:0]           w_req;
    logic [LW-1:0]           w_cmax;
    logic [LW-1:0]           w_lim_w;
    logic [COUNT_BITS-1:0]   w_limit;
    logic [SW-1:0]           w_bound;
    logic                    w_finish;
    logic                    w_out_free;
    logic                    w_in_acc;

    met_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    met_mul #(
        .OP_W (MW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    assign w_cre_ext = ZW'(i_c_re);
    assign w_cim_ext = ZW'(i_c_im);

    generate
        if (FRAC_BITS >= met_pkg::IN_FRAC) begin : g_align_up
            assign w_cr_in = w_cre_ext <<< (FRAC_BITS - met_pkg::IN_FRAC);
            assign w_ci_in = w_cim_ext <<< (FRAC_BITS - met_pkg::IN_FRAC);
        end else begin : g_align_dn
            assign w_cr_in = w_cre_ext >>> (met_pkg::IN_FRAC - FRAC_BITS);
            assign w_ci_in = w_cim_ext >>> (met_pkg::IN_FRAC - FRAC_BITS);
        end
    endgenerate

    assign w_req  = LW'(w_cfg.max_iter);
    assign w_cmax = LW'({COUNT_BITS{1'b1}});

    always_comb begin
        w_lim_w = (w_req == '0) ? LW'(1) : w_req;
        if (w_lim_w > w_cmax) begin
            w_lim_w = w_cmax;
        end
    end

    assign w_limit = COUNT_BITS'(w_lim_w);
    assign w_bound = SW'(w_cfg.esc_lim) << (2 * FRAC_BITS);

    always_comb begin
        unique case (r_state)
            S_MA: begin
                w_op_a = MW'(r_zr) - MW'(r_zi);
                w_op_b = MW'(r_zr) + MW'(r_zi);
            end
            S_MB: begin
                w_op_a = MW'(r_zr);
                w_op_b = MW'(r_zi);
            end
            S_SR: begin
                w_op_a = MW'(r_nr);
                w_op_b = MW'(r_nr);
            end
            S_SI: begin
                w_op_a = MW'(r_ni);
                w_op_b = MW'(r_ni);
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    assign w_start = !r_wait && (r_state == S_MA || r_state == S_MB ||
                                 r_state == S_SR || r_state == S_SI);

    assign w_nr_new   = ZW'(w_prod >>> FRAC_BITS) + r_cr;
    assign w_ni_new   = ZW'(w_prod >>> (FRAC_BITS - 1)) + r_ci;
    assign w_finish   = (r_count == w_limit) || !(r_sum < w_bound);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_TEST && w_finish && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_start) begin
                r_wait <= 1'b1;
            end else if (w_done) begin
                r_wait <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_MA;
                    end
                end
                S_MA: begin
                    if (w_done) begin
                        r_state <= S_MB;
                    end
                end
                S_MB: begin
                    if (w_done) begin
                        r_state <= S_SR;
                    end
                end
                S_SR: begin
                    if (w_done) begin
                        r_state <= S_SI;
                    end
                end
                S_SI: begin
                    if (w_done) begin
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (!w_finish) begin
                        r_state <= S_MA;
                    end else if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cr    <= w_cr_in;
            r_ci    <= w_ci_in;
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end
        if (w_done) begin
            case (r_state)
                S_MA: r_nr <= w_nr_new;
                S_MB: r_ni <= w_ni_new;
                S_SR: r_sr <= SW'(w_prod);
                S_SI: begin
                    r_sum   <= r_sr + SW'(w_prod);
                    r_zr    <= r_nr;
                    r_zi    <= r_ni;
                    r_count <= r_count + COUNT_BITS'(1);
                end
                default: ;
            endcase
        end
        if (r_state == S_TEST && w_finish && w_out_free) begin
            r_res_count  <= r_count;
            r_res_in_set <= (r_count == w_limit);
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_step_count = 16'(r_res_count);
    assign o_in_set     = r_res_in_set;

endmodule

`default_nettype wire

// ----- sim/tb_mandelbrot_escape_time_core.sv -----
// Self-checking testbench for the escape-time iteration core with randomized handshakes.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_core;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_point;

    typedef struct packed {
        logic [15:0] steps;
        logic        in_set;
    } t_escape;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic signed [31:0]             c_re = '0;
    logic signed [31:0]             c_im = '0;
    logic                           out_ready = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [met_pkg::ADDR_W-1:0]     paddr = '0;
    logic [met_pkg::DATA_W-1:0]     pwdata = '0;
    wire                            o_in_ready;
    wire                            o_out_valid;
    wire [15:0]                     o_step_count;
    wire                            o_in_set;
    wire [met_pkg::DATA_W-1:0]      prdata;
    wire                            pready;

    t_point      pending_points[$];
    t_escape     expected_escapes[$];
    logic [15:0] cfg_max_iter = met_pkg::DEF_MAX_ITER;
    logic [15:0] cfg_escape = met_pkg::DEF_ESCAPE;
    logic        in_hs = 1'b0;
    logic        out_hs = 1'b0;
    int          in_gap = 0;
    int          out_stall = 0;
    bit          in_idle_on = 1'b1;
    bit          out_idle_on = 1'b1;
    int          mismatches = 0;
    int          cfg_errors = 0;
    int          cycles = 0;

    mandelbrot_escape_time_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_c_re       (c_re),
        .i_c_im       (c_im),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_step_count (o_step_count),
        .o_in_set     (o_in_set),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_escape escape_count_of(input logic signed [31:0] re_in,
                                                input logic signed [31:0] im_in,
                                                input logic [15:0] max_iter,
                                                input logic [15:0] esc_lim);
        logic signed [127:0] zr;
        logic signed [127:0] zi;
        logic signed [127:0] nr;
        logic signed [127:0] ni;
        logic signed [127:0] cr;
        logic signed [127:0] ci;
        logic [127:0]        bound;
        logic [127:0]        mag_sq;
        int unsigned         limit;
        int unsigned         passes;
        logic                bounded;
        t_escape             res;
        cr = re_in;
        ci = im_in;
        zr = '0;
        zi = '0;
        limit = (max_iter == 16'd0) ? 1 : max_iter;
        bound = 128'(esc_lim) << (2 * met_pkg::FRAC_BITS);
        passes = 0;
        bounded = 1'b1;
        while (passes < limit && bounded) begin
            nr = (((zr - zi) * (zr + zi)) >>> met_pkg::FRAC_BITS) + cr;
            ni = ((zr * zi) >>> (met_pkg::FRAC_BITS - 1)) + ci;
            mag_sq = nr * nr + ni * ni;
            bounded = mag_sq < bound;
            zr = nr;
            zi = ni;
            passes++;
        end
        res.steps = passes[15:0];
        res.in_set = (passes == limit);
        return res;
    endfunction

    function automatic logic [31:0] corner_value();
        case ($urandom_range(0, 6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h2000_0000;
            5: return 32'hE000_0000;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic t_point random_point(input bit far_only);
        t_point      p;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (far_only) begin
            // A point at least 3 from the origin escapes within a few passes.
            p.re = $urandom_range(32'h3000_0000, 32'h7FFF_FFFF);
            if ($urandom_range(0, 1)) p.re = -p.re;
            p.im = $urandom;
        end else if (pick < 14) begin
            p.re = 32'($urandom_range(0, 671088640)) - 32'd536870912;
            p.im = 32'($urandom_range(0, 671088640)) - 32'd335544320;
        end else if (pick < 17) begin
            p.re = $urandom;
            p.im = $urandom;
        end else begin
            p.re = corner_value();
            p.im = corner_value();
        end
        return p;
    endfunction

    task automatic add_point(input logic signed [31:0] re, input logic signed [31:0] im);
        t_point p;
        p.re = re;
        p.im = im;
        pending_points.push_back(p);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_points.size() != 0 || in_valid || expected_escapes.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [15:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (idx == met_pkg::CFG_IDX_MAX_ITER) cfg_max_iter = value;
        else cfg_escape = value;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (prdata[15:0] !== value) begin
            if (cfg_errors < REPORT_MAX)
                $display("register %0d read back %h, expected %h", idx, prdata[15:0], value);
            cfg_errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] max_iter, input logic [15:0] esc_lim);
        wait_idle();
        cfg_write(met_pkg::CFG_IDX_MAX_ITER, max_iter);
        cfg_write(met_pkg::CFG_IDX_ESCAPE, esc_lim);
        in_idle_on = ($urandom_range(0, 2) != 0);
        out_idle_on = ($urandom_range(0, 2) != 0);
    endtask

    always @(posedge i_clk) begin : monitor
        t_escape got;
        t_escape want;
        in_hs <= i_rst_n && in_valid && o_in_ready;
        out_hs <= i_rst_n && o_out_valid && out_ready;
        if (i_rst_n && in_valid && o_in_ready)
            expected_escapes.push_back(escape_count_of(c_re, c_im, cfg_max_iter, cfg_escape));
        if (i_rst_n && o_out_valid && out_ready) begin
            got.steps = o_step_count;
            got.in_set = o_in_set;
            if (expected_escapes.size() == 0) begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected result: steps %0d in_set %0b", got.steps, got.in_set);
                mismatches++;
            end else begin
                want = expected_escapes.pop_front();
                if (got != want) begin
                    if (mismatches < REPORT_MAX)
                        $display("mismatch: expected steps %0d in_set %0b, got steps %0d in_set %0b",
                                 want.steps, want.in_set, got.steps, got.in_set);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge i_clk) begin : point_driver
        t_point nxt;
        if (!in_valid || in_hs) begin
            if (in_gap != 0) begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pending_points.size() != 0) begin
                nxt = pending_points.pop_front();
                c_re <= nxt.re;
                c_im <= nxt.im;
                in_valid <= 1'b1;
                in_gap <= in_idle_on ? $urandom_range(0, 18) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!out_ready || out_hs) begin
            if (out_stall != 0) begin
                out_ready <= 1'b0;
                out_stall <= out_stall - 1;
            end else begin
                out_ready <= 1'b1;
                out_stall <= out_idle_on ? $urandom_range(0, 18) : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int          ph;
        int          k;
        logic [15:0] lim;
        logic [15:0] esc;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: points inside the set run the full default limit.
        add_point(32'sh0000_0000, 32'sh0000_0000);
        add_point(-32'sh2000_0000, 32'sh0000_0000);
        add_point(32'sh0400_0000, 32'sh0000_0000);
        add_point(32'sh0000_0000, 32'sh1000_0000);
        add_point(-32'sh1000_0000, 32'sh0000_0000);
        add_point(-32'sh0000_0001, 32'sh0000_0000);
        add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        add_point(-32'sh8000_0000, -32'sh8000_0000);
        add_point(32'sh7FFF_FFFF, -32'sh8000_0000);
        add_point(-32'sh8000_0000, 32'sh7FFF_FFFF);
        add_point(32'sh0800_0000, 32'sh0800_0000);
        add_point(32'sh1000_0000, 32'sh0000_0000);
        add_point(-32'sh0C00_0000, 32'sh01C2_8F5C);
        add_point(32'sh0000_0000, -32'sh1199_999A);
        add_point(32'sh04CC_CCCD, -32'sh0800_0000);

        // A limit of one with a zero bound: every point stops after its first pass.
        set_config(16'd1, 16'd0);
        add_point(32'sh0000_0000, 32'sh0000_0000);
        add_point(32'sh7FFF_FFFF, 32'sh0000_0000);
        add_point(-32'sh8000_0000, 32'sh7FFF_FFFF);
        for (k = 0; k < 5; k++) pending_points.push_back(random_point(k[0]));

        // A zero limit acts as one.
        set_config(16'd0, 16'd4);
        for (k = 0; k < 40; k++) pending_points.push_back(random_point(1'b0));

        set_config(16'd65535, 16'd65535);
        for (k = 0; k < 30; k++) pending_points.push_back(random_point(1'b1));

        set_config(16'd65535, 16'd4);
        for (k = 0; k < 20; k++) pending_points.push_back(random_point(1'b1));

        set_config(16'd200, 16'd4);
        for (k = 0; k < 30; k++) pending_points.push_back(random_point(1'b0));

        for (ph = 0; ph < 9; ph++) begin
            lim = $urandom_range(2, 32);
            case ($urandom_range(0, 3))
                0: esc = 16'd4;
                1: esc = 16'd40000;
                2: esc = $urandom_range(5, 65535);
                default: esc = $urandom_range(0, 16);
            endcase
            set_config(lim, esc);
            for (k = 0; k < 115; k++) pending_points.push_back(random_point(1'b0));
        end

        wait_idle();
        if (mismatches == 0 && cfg_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
